@@ sv/quad_encoder_button_event_decoder_defines.svh @@
// assertion macros shared by the decoder modules
// expects clk_i and rst_ni in the scope of each use
`ifndef QUAD_ENCODER_BUTTON_EVENT_DECODER_DEFINES_SVH
`define QUAD_ENCODER_BUTTON_EVENT_DECODER_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define QEBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define QEBD_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

@@ sv/qebd_pkg.sv @@
// types, constants and lookup functions of the encoder and button event decoder
// no dependencies
`default_nettype none

package qebd_pkg;

  localparam int unsigned ENC_MAX     = 4;
  localparam int unsigned BTN_COUNT   = 8;
  localparam int unsigned SLOT_COUNT  = ENC_MAX + BTN_COUNT;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0]        PPS_RESET    = 8'h01;
  localparam logic [1:0]        ENC_IDLE     = 2'b11;
  localparam logic [7:0]        BTN_RELEASED = 8'hFF;
  localparam logic signed [9:0] ACC_MAX      = 10'sd255;
  localparam logic signed [9:0] ACC_MIN      = -10'sd255;

  // port a bit scanned at each button slot
  localparam logic [2:0] BTN_ORDER [BTN_COUNT] = '{
    3'd3, 3'd2, 3'd1, 3'd0, 3'd7, 3'd6, 3'd5, 3'd4
  };

  typedef enum logic [2:0] {
    EV_STEP_UP   = 3'd0,
    EV_STEP_DOWN = 3'd1,
    EV_SELECT    = 3'd2,
    EV_HOME      = 3'd3,
    EV_BACK      = 3'd4,
    EV_PROG_UP   = 3'd5,
    EV_PROG_DOWN = 3'd6
  } event_code_e;

  typedef enum logic [0:0] {
    REG_PPS = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] port_a;
    logic [7:0] port_b;
  } poll_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic [3:0] source;
    logic       last;
  } event_t;

  typedef struct packed {
    logic [SLOT_COUNT-1:0] mask;
    logic [ENC_MAX-1:0]    down;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qxfer_t;

  // direction of one quadrature transition, index is prev and cur state
  function automatic logic signed [1:0] quad_dir(input logic [3:0] idx);
    logic signed [1:0] d;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  d = 2'sb11;
      4'd2, 4'd4, 4'd11, 4'd13: d = 2'sb01;
      default:                  d = 2'sb00;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] slot_code(input logic [3:0] k, input logic down);
    event_code_e c;
    unique case (k)
      4'd0, 4'd1, 4'd2, 4'd3: c = down ? EV_STEP_DOWN : EV_STEP_UP;
      4'd4, 4'd5, 4'd6, 4'd7: c = EV_SELECT;
      4'd8:                   c = EV_HOME;
      4'd9:                   c = EV_BACK;
      4'd10:                  c = EV_PROG_UP;
      4'd11:                  c = EV_PROG_DOWN;
      default:                c = EV_STEP_UP;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] slot_source(input logic [3:0] k);
    logic [3:0] j;
    logic [3:0] s;
    j = k - 4'd4;
    if (k < 4'(ENC_MAX)) begin
      s = k;
    end else begin
      s = {1'b0, BTN_ORDER[j[2:0]]} + 4'd4;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

@@ sv/quad_encoder_button_event_decoder.sv @@
// quadrature encoder and button event decoder, top level; depends on qebd_pkg,
// qebd_front, qebd_fifo and qebd_back
// input channel: one poll per transfer (port_a buttons, port_b four encoders)
// output channel: one event per transfer, last marks the final event of a poll
// apb port: register 0 is pulses_per_step, zero acts as one, reset value 1
// a poll is taken on one transfer; the front updates encoder and button state and
// queues a mask of the events it causes, a poll with no events queues nothing
// the back end walks each mask and issues one event per cycle from an output
// register while out_ready_i is high, so a poll with n events yields n events
// the first event of a poll passes the queue, the pending mask and the output
// register; throughput: one poll per cycle while the two-entry queue has room,
// one event per cycle when out_ready_i is high, set by the one output register
// reset clears encoder states to both channels high, accumulators to zero,
// buttons to released and empties the queue; no clearing pass is needed
// when the receiver stalls, the output holds, the queue fills and in_ready_o
// drops once both queue entries are taken
`default_nettype none

module quad_encoder_button_event_decoder #(
  parameter int unsigned ENCODER_COUNT = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  qebd_pkg::poll_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output qebd_pkg::event_t out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import qebd_pkg::*;

  logic [7:0] pps_q;
  logic [7:0] pps_d;
  logic       cfg_wr;
  logic       full;
  qxfer_t     push;
  qxfer_t     head;
  logic       pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pps_d  = (cfg_wr && (paddr[2] == REG_PPS)) ? pwdata[7:0] : pps_q;
  assign prdata = (paddr[2] == REG_PPS) ? {24'b0, pps_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pps_q <= PPS_RESET;
    end else begin
      pps_q <= pps_d;
    end
  end

  qebd_front #(
    .ENCODER_COUNT(ENCODER_COUNT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .pps_i     (pps_q),
    .full_i    (full),
    .push_o    (push)
  );

  qebd_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .full_o(full),
    .head_o(head),
    .pop_i (pop)
  );

  qebd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

@@ sv/qebd_front.sv @@
// front end: takes polls, tracks encoder and button state, builds event masks
// depends on qebd_pkg
`default_nettype none

module qebd_front #(
  parameter int unsigned ENCODER_COUNT = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  qebd_pkg::poll_t in_data_i,
  input  logic [7:0]      pps_i,
  input  logic            full_i,
  output qebd_pkg::qxfer_t push_o
);
  import qebd_pkg::*;

  localparam int unsigned ENC_N = (ENCODER_COUNT > ENC_MAX) ? ENC_MAX : ENCODER_COUNT;

  logic               accept;
  logic [7:0]         thr;
  logic signed [9:0]  thr_s;
  logic [ENC_MAX-1:0] fire_up;
  logic [ENC_MAX-1:0] fire_dn;
  logic [7:0]         btn_q;
  logic [7:0]         btn_d;
  logic [7:0]         pressed;
  logic [SLOT_COUNT-1:0] mask;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign thr        = (pps_i == 8'd0) ? 8'd1 : pps_i;
  assign thr_s      = $signed({2'b00, thr});

  for (genvar e = 0; e < ENC_MAX; e++) begin : g_enc
    if (e < ENC_N) begin : g_on
      logic [1:0]        cur;
      logic [1:0]        prev_q;
      logic signed [1:0] dir;
      logic signed [8:0] acc_q;
      logic signed [8:0] acc_d;
      logic signed [9:0] sum;
      logic signed [9:0] sat;
      logic              changed;

      always_comb begin
        cur     = in_data_i.port_b[2*e +: 2];
        changed = (cur != prev_q);
        dir     = quad_dir({prev_q, cur});
        sum     = $signed({acc_q[8], acc_q}) + $signed({{8{dir[1]}}, dir});
        if (sum > ACC_MAX) begin
          sat = ACC_MAX;
        end else if (sum < ACC_MIN) begin
          sat = ACC_MIN;
        end else begin
          sat = sum;
        end
        fire_up[e] = changed && (sat >= thr_s);
        fire_dn[e] = changed && !fire_up[e] && (sat <= -thr_s);
        if (!changed) begin
          acc_d = acc_q;
        end else if (fire_up[e] || fire_dn[e]) begin
          acc_d = '0;
        end else begin
          acc_d = sat[8:0];
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          prev_q <= ENC_IDLE;
          acc_q  <= '0;
        end else if (accept) begin
          prev_q <= cur;
          acc_q  <= acc_d;
        end
      end
    end else begin : g_off
      assign fire_up[e] = 1'b0;
      assign fire_dn[e] = 1'b0;
    end
  end

  assign pressed = btn_q & ~in_data_i.port_a;
  assign btn_d   = accept ? in_data_i.port_a : btn_q;

  always_comb begin
    mask[ENC_MAX-1:0] = fire_up | fire_dn;
    for (int i = 0; i < BTN_COUNT; i++) begin
      mask[ENC_MAX + i] = pressed[BTN_ORDER[i]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_q <= BTN_RELEASED;
    end else begin
      btn_q <= btn_d;
    end
  end

  assign push_o.valid      = accept && (mask != '0);
  assign push_o.entry.mask = mask;
  assign push_o.entry.down = fire_dn;

endmodule

`default_nettype wire

@@ sv/qebd_fifo.sv @@
// short queue of per-poll event masks between front and back end
// depends on qebd_pkg and the assertion macro header
`default_nettype none
`include "quad_encoder_button_event_decoder_defines.svh"

module qebd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  qebd_pkg::qxfer_t push_i,
  output logic             full_o,
  output qebd_pkg::qxfer_t head_o,
  input  logic             pop_i
);
  import qebd_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [PTR_W-1:0] rd_ptr_d;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  `QEBD_ASSERT_NEVER(a_push_full, push_i.valid && full_o, "push into full queue")
  `QEBD_ASSERT_NEVER(a_pop_empty, pop_i && !head_o.valid, "pop from empty queue")
  `QEBD_ASSERT(a_count_range, count_q <= CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

@@ sv/qebd_back.sv @@
// back end: walks one event mask per poll and serializes events to the output register
// depends on qebd_pkg and the assertion macro header
`default_nettype none
`include "quad_encoder_button_event_decoder_defines.svh"

module qebd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  qebd_pkg::qxfer_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output qebd_pkg::event_t out_data_o
);
  import qebd_pkg::*;

  logic [SLOT_COUNT-1:0] pend_q;
  logic [SLOT_COUNT-1:0] pend_d;
  logic [SLOT_COUNT-1:0] onehot;
  logic [SLOT_COUNT-1:0] rem;
  logic [ENC_MAX-1:0]    down_q;
  logic [ENC_MAX-1:0]    down_d;
  logic [3:0]            sel;
  logic                  found;
  logic                  slot_free;
  logic                  emit;
  logic                  last;
  logic                  load;
  logic                  out_valid_q;
  logic                  out_valid_d;
  event_t                out_q;
  event_t                out_d;

  // first pending slot in scan order
  always_comb begin
    found  = 1'b0;
    sel    = '0;
    onehot = '0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if (pend_q[k] && !found) begin
        found     = 1'b1;
        sel       = 4'(k);
        onehot[k] = 1'b1;
      end
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = slot_free && found;
  assign rem       = pend_q & ~onehot;
  assign last      = (rem == '0);
  assign load      = head_i.valid && (!found || (emit && last));
  assign pop_o     = load;

  always_comb begin
    pend_d = pend_q;
    down_d = down_q;
    if (load) begin
      pend_d = head_i.entry.mask;
      down_d = head_i.entry.down;
    end else if (emit) begin
      pend_d = rem;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d      = 1'b1;
      out_d.event_code = slot_code(sel, down_q[sel[1:0]]);
      out_d.source     = slot_source(sel);
      out_d.last       = last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    down_q <= down_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `QEBD_ASSERT(a_load_nonempty, load |=> (pend_q != '0), "loaded an empty event mask")
  `QEBD_ASSERT(a_more_pending, (emit && !last) |=> (pend_q != '0), "events lost before last")
  `QEBD_ASSERT(a_emit_shows, emit |=> out_valid_q, "emitted event not presented")

endmodule

`default_nettype wire
